>>> rtl/core/atr_pkg.sv
// Shared types and constants for the accelerometer tilt ratio block.
// No dependencies; imported by every module under rtl/core.
package atr_pkg;

   // Input beat: one converter sample per axis
   typedef struct packed {
      logic [7:0] sample_x;
      logic [7:0] sample_y;
      logic [7:0] sample_z;
   } atr_req_type;

   // Result beat: one ratio of the pair
   typedef struct packed {
      logic              angle_id;
      logic signed [31:0] tilt_ratio;
      logic              zero_denominator;
      logic              last;
   } atr_rsp_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic done;
      logic ovf;
   } atr_div_status_type;

   // Axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Result pair codes: y over x,z first, then x over y,z
   localparam logic ID_Y_OVER_XZ = 1'b0;
   localparam logic ID_X_OVER_YZ = 1'b1;

   // Zero-g code after reset
   localparam logic [7:0] ZERO_G_RESET = 8'd127;

   // Q16.16 limits
   localparam logic [31:0] RATIO_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] RATIO_NEG_MAX = 32'h8000_0000;

   // Fraction bits of the quotient
   localparam int FRAC_W = 16;
   localparam int QUO_W  = 32;

endpackage

>>> rtl/core/accel_tilt_ratio_from_window_sums.sv
// Tilt ratio block top level: accumulator, shared squarer and divider sequencer.
// Depends on atr_pkg, atr_accum and atr_divider.
//
// Usage: req_ carries one x/y/z sample beat, accepted when req_valid is high
// and req_stall low. While a window fills, a beat is taken every cycle. The
// beat that completes WINDOW samples closes the window; the block then holds
// req_stall high while it works out the pair of results and delivers them.
// rsp_ delivers two beats per window: angle_id 0 (y over x,z) and then
// angle_id 1 (x over y,z, last set). Each ratio is signed Q16.16, saturated.
// Work per window close: offset removal, squaring of each axis in turn on one
// shared multiplier, sums, then per result an issue step, the divider
// (overflow check, 32 quotient bits, done flag) and an output step; req_stall
// stays high for the pair, plus any rsp_stall time. A zero denominator skips
// the divider. A result waits in the output register while rsp_stall is high;
// the block stalls the input until both results are taken. The user is to
// write zero_g_level over csr_ only while the block is idle; the block itself
// does not enforce it (csr_ready is always high). Reset clears the sums and
// counter and sets zero_g_level to 127.
module accel_tilt_ratio_from_window_sums import atr_pkg::*; #(
   parameter int WINDOW = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  atr_req_type  req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output atr_rsp_type  rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);

   localparam int SUM_W = $clog2(255 * WINDOW + 1);
   localparam int NUM_W = 2 * SUM_W;
   localparam int DEN_W = NUM_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEV,
      S_SQ,
      S_SUM,
      S_DIV,
      S_WAIT_DIV,
      S_OUT
   } seq_state_type;

   seq_state_type       state_ff;
   logic [7:0]          zero_g_ff;
   logic [SUM_W-1:0]    sums [3];
   logic                take;
   logic                close;
   logic                clear;
   logic [SUM_W-1:0]    mag_ff [3];
   logic                neg_ff [3];
   logic [NUM_W-1:0]    sq_ff [3];
   logic [DEN_W-1:0]    den_ff [2];
   logic [1:0]          axis_ff;
   logic                pair_ff;
   logic                rsp_valid_ff;
   atr_rsp_type         rsp_ff;
   logic [SUM_W-1:0]    offset_in;
   logic [SUM_W:0]      dev_in [3];
   logic [SUM_W-1:0]    mag_sel_in;
   logic [NUM_W-1:0]    prod_in;
   logic [NUM_W-1:0]    num_in;
   logic [DEN_W-1:0]    den_in;
   logic                neg_in;
   logic                div_start;
   logic [QUO_W-1:0]    quotient;
   atr_div_status_type  div_status;
   logic [QUO_W-1:0]    ratio_in;

   assign take      = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign clear     = (state_ff == S_DEV);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // zero-g register
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_g_ff <= ZERO_G_RESET;
      end else if (csr_valid && csr_ready) begin
         zero_g_ff <= csr_data;
      end
   end

   atr_accum #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_accum (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .sample (req_data),
      .clear  (clear),
      .sums   (sums),
      .close  (close)
   );

   // offset removal, one shared squarer, operand select for the divider
   always_comb begin
      offset_in = SUM_W'(zero_g_ff) * SUM_W'(WINDOW);
      for (int i = 0; i < 3; i++) begin
         dev_in[i] = {1'b0, sums[i]} - {1'b0, offset_in};
      end
      mag_sel_in = mag_ff[axis_ff];
      prod_in    = NUM_W'(mag_sel_in) * NUM_W'(mag_sel_in);
      if (pair_ff == ID_Y_OVER_XZ) begin
         num_in = sq_ff[AXIS_Y];
         neg_in = neg_ff[AXIS_Y];
      end else begin
         num_in = sq_ff[AXIS_X];
         neg_in = neg_ff[AXIS_X];
      end
      den_in    = den_ff[pair_ff];
      div_start = (state_ff == S_DIV) && (den_in != '0);
      // sign and saturation of the quotient
      if (neg_in) begin
         if (div_status.ovf || (quotient > RATIO_NEG_MAX)) begin
            ratio_in = RATIO_NEG_MAX;
         end else begin
            ratio_in = '0 - quotient;
         end
      end else begin
         if (div_status.ovf || quotient[QUO_W-1]) begin
            ratio_in = RATIO_POS_MAX;
         end else begin
            ratio_in = quotient;
         end
      end
   end

   atr_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_in),
      .den      (den_in),
      .quotient (quotient),
      .status   (div_status)
   );

   // window-close sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= AXIS_X;
         pair_ff      <= ID_Y_OVER_XZ;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (close) begin
                  state_ff <= S_DEV;
               end
            end
            S_DEV: begin
               for (int i = 0; i < 3; i++) begin
                  neg_ff[i] <= dev_in[i][SUM_W];
                  mag_ff[i] <= dev_in[i][SUM_W] ? SUM_W'(-dev_in[i]) : dev_in[i][SUM_W-1:0];
               end
               axis_ff  <= AXIS_X;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               sq_ff[axis_ff] <= prod_in;
               if (axis_ff == AXIS_Z) begin
                  state_ff <= S_SUM;
               end else begin
                  axis_ff <= axis_ff + 1'b1;
               end
            end
            S_SUM: begin
               den_ff[ID_Y_OVER_XZ] <= DEN_W'(sq_ff[AXIS_X]) + DEN_W'(sq_ff[AXIS_Z]);
               den_ff[ID_X_OVER_YZ] <= DEN_W'(sq_ff[AXIS_Y]) + DEN_W'(sq_ff[AXIS_Z]);
               pair_ff              <= ID_Y_OVER_XZ;
               state_ff             <= S_DIV;
            end
            S_DIV: begin
               if (den_in == '0) begin
                  rsp_ff.angle_id         <= pair_ff;
                  rsp_ff.tilt_ratio       <= '0;
                  rsp_ff.zero_denominator <= 1'b1;
                  rsp_ff.last             <= pair_ff;
                  rsp_valid_ff            <= 1'b1;
                  state_ff                <= S_OUT;
               end else begin
                  state_ff <= S_WAIT_DIV;
               end
            end
            S_WAIT_DIV: begin
               if (div_status.done) begin
                  rsp_ff.angle_id         <= pair_ff;
                  rsp_ff.tilt_ratio       <= ratio_in;
                  rsp_ff.zero_denominator <= 1'b0;
                  rsp_ff.last             <= pair_ff;
                  rsp_valid_ff            <= 1'b1;
                  state_ff                <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (pair_ff == ID_Y_OVER_XZ) begin
                     pair_ff  <= ID_X_OVER_YZ;
                     state_ff <= S_DIV;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/core/atr_accum.sv
// Window accumulator: per-axis sample sums and window sample counter.
// Depends on atr_pkg.
module atr_accum import atr_pkg::*; #(
   parameter int WINDOW = 64,
   parameter int SUM_W  = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  atr_req_type       sample,
   input  logic              clear,
   output logic [SUM_W-1:0]  sums [3],
   output logic              close
);

   localparam int CNT_W = (WINDOW > 2) ? $clog2(WINDOW) : 1;

   logic [SUM_W-1:0] sum_ff [3];
   logic [CNT_W-1:0] count_ff;
   logic [7:0]       smp [3];

   assign smp[0] = sample.sample_x;
   assign smp[1] = sample.sample_y;
   assign smp[2] = sample.sample_z;

   // window closes on the beat that fills the last slot
   assign close = take && (count_ff == CNT_W'(WINDOW - 1));

   assign sums = sum_ff;

   // sums and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         if (clear) begin
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= '0;
            end
         end else if (take) begin
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= sum_ff[i] + SUM_W'(smp[i]);
            end
         end
         if (take) begin
            count_ff <= close ? '0 : count_ff + 1'b1;
         end
      end
   end

endmodule

>>> rtl/core/atr_divider.sv
// Iterative restoring divider: (num << 16) / den, one quotient bit a cycle,
// with an up-front overflow check for quotients of 2^32 and above. Needs atr_pkg.
module atr_divider import atr_pkg::*; #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 29
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_W-1:0]    num,
   input  logic [DEN_W-1:0]    den,
   output logic [QUO_W-1:0]    quotient,
   output atr_div_status_type  status
);

   localparam int CMP_W = DEN_W + FRAC_W;

   typedef enum logic [1:0] {
      D_IDLE,
      D_CHECK,
      D_RUN
   } div_state_type;

   div_state_type        state_ff;
   atr_div_status_type   status_ff;
   logic [NUM_W-1:0]     num_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [QUO_W-1:0]     sh_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [4:0]           cnt_ff;
   logic [DEN_W:0]       trial_in;
   logic [DEN_W:0]       diff_in;
   logic                 fits_in;
   logic                 ovf_in;

   // one trial subtraction per cycle
   always_comb begin
      trial_in = {rem_ff, sh_ff[QUO_W-1]};
      diff_in  = trial_in - {1'b0, den_ff};
      fits_in  = trial_in >= {1'b0, den_ff};
      ovf_in   = CMP_W'(num_ff) >= {den_ff, {FRAC_W{1'b0}}};
   end

   assign quotient = quo_ff;
   assign status   = status_ff;

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= D_IDLE;
         status_ff <= '0;
      end else begin
         status_ff.done <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  num_ff   <= num;
                  den_ff   <= den;
                  state_ff <= D_CHECK;
               end
            end
            D_CHECK: begin
               if (ovf_in) begin
                  status_ff.done <= 1'b1;
                  status_ff.ovf  <= 1'b1;
                  quo_ff         <= '0;
                  state_ff       <= D_IDLE;
               end else begin
                  // high part of the shifted dividend is already below den
                  rem_ff         <= DEN_W'(num_ff >> FRAC_W);
                  sh_ff          <= {num_ff[FRAC_W-1:0], {(QUO_W - FRAC_W){1'b0}}};
                  cnt_ff         <= '1;
                  status_ff.ovf  <= 1'b0;
                  state_ff       <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= fits_in ? diff_in[DEN_W-1:0] : trial_in[DEN_W-1:0];
               quo_ff <= {quo_ff[QUO_W-2:0], fits_in};
               sh_ff  <= {sh_ff[QUO_W-2:0], 1'b0};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  status_ff.done <= 1'b1;
                  state_ff       <= D_IDLE;
               end
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

endmodule

>>> tb/accel_tilt_ratio_from_window_sums_tb.sv
// Self-checking bench for the accelerometer tilt ratio block: random and directed
// sample beats, a window-sum predictor and an in-order check of every ratio beat.
// Depends on atr_pkg and accel_tilt_ratio_from_window_sums.
module accel_tilt_ratio_from_window_sums_tb;
   import atr_pkg::*;

   localparam int SAMPLES_PER_WINDOW = 64;
   localparam int SETTLE_CYCLES      = 100;    // a little over one window close
   localparam int CYCLE_LIMIT        = 1_000_000;
   localparam int HOLD_OFF_CYCLES    = 600;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   atr_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   atr_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data  = '0;

   atr_req_type pending_samples[$];
   atr_rsp_type expected_ratios[$];
   int          mismatches = 0;
   int          cycles     = 0;

   // predictor copy of the block state
   logic [7:0]  model_zero_g = ZERO_G_RESET;
   int          acc_x = 0, acc_y = 0, acc_z = 0, acc_count = 0;

   // pacing state of both sides
   int          gap_left = 0, send_quiet = 0;
   int          stall_left = 0, recv_quiet = 0;
   int          hold_left = 0, beats_seen = 0;

   accel_tilt_ratio_from_window_sums #(.WINDOW(SAMPLES_PER_WINDOW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly short idle runs, now and then a long one
   function automatic int idle_length();
      int pick = $urandom_range(0, 999);
      if (pick < 550) return 0;
      if (pick < 900) return $urandom_range(1, 3);
      if (pick < 985) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // sign(n) * n^2 / (a^2 + b^2) in Q16.16, truncated magnitude, saturated
   function automatic atr_rsp_type predict_ratio(logic angle, int n, int a, int b,
                                                 logic second);
      longint unsigned mn, ma, mb, num, den, quo;
      atr_rsp_type     r;
      mn  = longint'(n < 0 ? -n : n);
      ma  = longint'(a < 0 ? -a : a);
      mb  = longint'(b < 0 ? -b : b);
      num = mn * mn;
      den = ma * ma + mb * mb;
      r = '0;
      r.angle_id = angle;
      r.last     = second;
      if (den == 0) begin
         r.zero_denominator = 1'b1;
      end else begin
         quo = (num << FRAC_W) / den;
         if (n < 0) begin
            if (quo > RATIO_NEG_MAX) quo = RATIO_NEG_MAX;
            r.tilt_ratio = -quo[31:0];
         end else begin
            if (quo > RATIO_POS_MAX) quo = RATIO_POS_MAX;
            r.tilt_ratio = quo[31:0];
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, logic signed [32:0] want,
                              logic signed [32:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // One window of a steady sample with its closing beat set apart
   task automatic queue_window(input logic [7:0] x, y, z, lx, ly, lz);
      for (int i = 0; i < SAMPLES_PER_WINDOW - 1; i++)
         pending_samples.push_back('{x, y, z});
      pending_samples.push_back('{lx, ly, lz});
   endtask

   // Random beats: each stretch of a window gets per-axis bias and spread
   task automatic queue_random(input int count);
      int         bias[3], spread[3], style, v;
      logic [7:0] code[3];
      for (int i = 0; i < count; i++) begin
         if (i % SAMPLES_PER_WINDOW == 0) begin
            for (int a = 0; a < 3; a++) begin
               style = $urandom_range(0, 9);
               if (style < 4) bias[a] = $urandom_range(0, 255);
               else if (style < 7) bias[a] = int'(model_zero_g) + int'($urandom_range(0, 2)) - 1;
               else if (style < 8) bias[a] = 0;
               else bias[a] = 255;
               case ($urandom_range(0, 3))
                  0: spread[a] = 0;
                  1: spread[a] = 1;
                  2: spread[a] = 6;
                  default: spread[a] = 128;
               endcase
            end
         end
         for (int a = 0; a < 3; a++) begin
            if ($urandom_range(0, 15) == 0) begin
               v = $urandom_range(0, 255);   // stray noise beat
            end else begin
               v = bias[a] + int'($urandom_range(0, 2 * spread[a])) - spread[a];
            end
            code[a] = v < 0 ? 8'd0 : v > 255 ? 8'd255 : v[7:0];
         end
         pending_samples.push_back('{code[0], code[1], code[2]});
      end
   endtask

   // Block is idle: nothing queued, nothing in flight, nothing owed
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_ratios.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_zero_g(input logic [7:0] level);
      csr_data  <= level;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_zero_g = level;
   endtask

   // Sample beat driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            req_data  <= pending_samples.pop_front();
            req_valid <= 1'b1;
            if (send_quiet > 0) begin
               send_quiet--;
               gap_left = 0;
            end else begin
               if ($urandom_range(0, 199) == 0) send_quiet = 150;
               gap_left = idle_length();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predictor: fold each accepted beat into the window sums
   always @(posedge clock) begin : window_predictor
      int dx, dy, dz;
      if (!reset && req_valid && !req_stall) begin
         acc_x += req_data.sample_x;
         acc_y += req_data.sample_y;
         acc_z += req_data.sample_z;
         acc_count++;
         if (acc_count == SAMPLES_PER_WINDOW) begin
            dx = acc_x - int'(model_zero_g) * SAMPLES_PER_WINDOW;
            dy = acc_y - int'(model_zero_g) * SAMPLES_PER_WINDOW;
            dz = acc_z - int'(model_zero_g) * SAMPLES_PER_WINDOW;
            expected_ratios.push_back(predict_ratio(ID_Y_OVER_XZ, dy, dx, dz, 1'b0));
            expected_ratios.push_back(predict_ratio(ID_X_OVER_YZ, dx, dy, dz, 1'b1));
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            acc_count = 0;
         end
      end
   end

   // Long receiver hold-off at two points in the run so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else begin
         if (req_valid && !req_stall) beats_seen++;
         if (hold_left > 0) hold_left <= hold_left - 1;
         else if (req_valid && !req_stall && (beats_seen == 700 || beats_seen == 1700))
            hold_left <= HOLD_OFF_CYCLES;
      end
   end

   // Result check and receiver stall
   always @(posedge clock) begin : ratio_check
      atr_rsp_type want;
      logic        stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_ratios.size() == 0) begin
               $display("%0t: ratio beat with nothing expected: angle %0d ratio %0d",
                        $time, rsp_data.angle_id, rsp_data.tilt_ratio);
               mismatches++;
            end else begin
               want = expected_ratios.pop_front();
               check_field("angle_id", want.angle_id, rsp_data.angle_id);
               check_field("tilt_ratio", want.tilt_ratio, rsp_data.tilt_ratio);
               check_field("zero_denominator", want.zero_denominator,
                           rsp_data.zero_denominator);
               check_field("last", want.last, rsp_data.last);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
            if (recv_quiet > 0) begin
               recv_quiet--;
            end else begin
               if ($urandom_range(0, 299) == 0) recv_quiet = 200;
               stall_left = idle_length();
            end
         end
         rsp_stall <= stall_next || hold_left > 1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("accel_tilt_ratio_from_window_sums regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0] levels[7];
      levels = '{8'd0, 8'd255, 8'd128, 8'd0, 8'd127, 8'd254, 8'd0};
      levels[3] = 8'($urandom_range(0, 255));
      levels[6] = 8'($urandom_range(0, 255));
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed windows at the reset zero-g level
      queue_window(127, 127, 127, 127, 127, 127);   // all sums at zero g
      queue_window(255, 0, 127, 255, 0, 127);       // opposite signs
      queue_window(127, 255, 127, 127, 255, 128);   // tiny denominator, clips high
      queue_window(127, 0, 127, 127, 0, 128);       // tiny denominator, clips low
      queue_window(127, 200, 127, 127, 200, 127);   // zero denominator, nonzero top
      queue_window(0, 0, 0, 0, 0, 0);               // field minimum
      queue_window(255, 255, 255, 255, 255, 255);   // field maximum
      queue_window(130, 125, 120, 131, 125, 121);   // truncation of a negative ratio

      // Random phases, each under its own zero-g level; the short first one
      // leaves the next write landing inside an open window
      for (int p = 0; p < 7; p++) begin
         wait_idle();
         write_zero_g(levels[p]);
         queue_random(p == 0 ? 100 : $urandom_range(180, 230));
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("accel_tilt_ratio_from_window_sums regression: pass");
      end else begin
         $display("accel_tilt_ratio_from_window_sums regression: fail");
      end
      $finish;
   end

endmodule
